### sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, no reset gating
`define CSRSPMV_ASSERT_NOW(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |-> (c)) else $error("assertion failed");

// same-cycle implication, gated by reset
`define CSRSPMV_ASSERT_IMPL(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error("assertion failed");

// next-cycle implication, gated by reset
`define CSRSPMV_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error("assertion failed");

`endif

### sv/csrspmv_pkg.sv
// Types, constants and float helpers for the CSR SpMV core
package csrspmv_pkg;

  localparam int VecDepthDefault = 1024;
  localparam int ValueW = 32;
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_NONZERO = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  index;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [31:0] row_sum;
    logic [15:0] row_number;
  } out_t;

  // queue entry: close marker or a nonzero with its vector operand
  typedef struct packed {
    logic        close;
    logic [31:0] mval;
    logic [31:0] xval;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_beat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MNORM,
    B_ADD,
    B_ANORM
  } bstate_t;

  // right shift with the lost bits folded into bit 0
  function automatic logic [47:0] shr_sticky(input logic [47:0] m, input logic [10:0] sh);
    logic [47:0] r;
    logic [47:0] mask;
    mask = '0;
    if (sh >= 11'd48) begin
      r = {47'b0, |m};
    end else begin
      r = m >> sh;
      mask = ~({48{1'b1}} << sh);
      r[0] = r[0] | (|(m & mask));
    end
    return r;
  endfunction

  // m has its leading one at bit 47, value 1.f * 2^(x-127); round to nearest even
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] x,
                                             input logic [47:0] m);
    logic [47:0] mm;
    logic [23:0] keep;
    logic g;
    logic st;
    logic rnd;
    logic [24:0] sum;
    logic signed [11:0] e;
    logic [31:0] res;
    if (x >= 11'sd1) mm = m;
    else mm = shr_sticky(m, 11'(11'sd1 - x));
    keep = mm[47:24];
    g = mm[23];
    st = |mm[22:0];
    rnd = g & (st | keep[0]);
    sum = {1'b0, keep} + {24'b0, rnd};
    e = {x[10], x} + {11'b0, sum[24]};
    if (x >= 11'sd1) begin
      if (e >= 12'sd255) res = {s, 8'hFF, 23'b0};
      else res = {s, e[7:0], (sum[24] ? sum[23:1] : sum[22:0])};
    end else begin
      // subnormal; a carry into bit 23 lands on the smallest normal
      res = {s, 7'b0, sum[23], sum[22:0]};
    end
    return res;
  endfunction

  // final fine shift (top byte is nonzero) then round
  function automatic logic [31:0] norm_round(input logic s, input logic signed [10:0] x,
                                             input logic [47:0] m);
    logic [2:0] lz;
    lz = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (m[40+i]) lz = 3'(7 - i);
    end
    return round_pack(s, x - signed'({8'b0, lz}), m << lz);
  endfunction

endpackage

### sv/csrspmv_ram.sv
// Generic single-write, single-read RAM with registered read data
module csrspmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### sv/csrspmv_front.sv
// Front end: accepts beats, writes the vector store, fetches operands into the queue
module csrspmv_front import csrspmv_pkg::*; #(
  parameter int VEC_DEPTH = VecDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  in_t              item,
  output logic             item_stall,
  input  logic [QCntW-1:0] q_count,
  output q_beat_t          push
);

  localparam int AddrW = $clog2(VEC_DEPTH);

  logic             accept;
  logic             in_range;
  logic             wr_en;
  logic [AddrW-1:0] addr;
  logic [31:0]      rd;
  logic             pend_valid;
  logic             pend_close;
  logic [31:0]      pend_mval;
  logic             pend_inr;

  // a beat taken now waits in the pending register before it is written to the queue; reserve its slot
  assign item_stall = ({1'b0, q_count} + {{QCntW{1'b0}}, pend_valid}) >= (QCntW + 1)'(QDepth);
  assign accept = item_valid && !item_stall;
  assign in_range = int'(item.index) < VEC_DEPTH;
  assign addr = AddrW'(item.index);
  assign wr_en = accept && (item.mode == MODE_LOAD) && in_range;

  csrspmv_ram #(
    .WIDTH(ValueW),
    .DEPTH(VEC_DEPTH)
  ) u_vec (
    .clk  (clk),
    .we   (wr_en),
    .waddr(addr),
    .wdata(item.value),
    .raddr(addr),
    .rdata(rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= accept && ((item.mode == MODE_NONZERO) || (item.mode == MODE_CLOSE));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_close <= (item.mode == MODE_CLOSE);
      pend_mval <= item.value;
      pend_inr <= in_range;
    end
  end

  always_comb begin
    push.valid = pend_valid;
    push.op.close = pend_close;
    push.op.mval = pend_mval;
    push.op.xval = pend_inr ? rd : 32'h0;
  end

endmodule

### sv/csrspmv_fifo.sv
// Short operation queue between front and back
module csrspmv_fifo import csrspmv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  q_beat_t          push,
  input  logic             pop,
  output q_beat_t          head,
  output logic [QCntW-1:0] count
);

  op_t               mem [QDepth];
  logic [QAddrW-1:0] wp;
  logic [QAddrW-1:0] rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push.valid) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + QCntW'(push.valid) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem[wp] <= push.op;
  end

  always_comb begin
    head.valid = (count != '0);
    head.op = mem[rp];
  end

endmodule

### sv/csrspmv_back.sv
// Back end: float multiply, row accumulate, close-row result register
module csrspmv_back import csrspmv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_beat_t head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output out_t    result
);

  bstate_t state;
  bstate_t state_next;

  logic [47:0]        mant;
  logic signed [10:0] xexp;
  logic               sgn;
  logic               spec;
  logic [31:0]        spec_bits;
  logic [31:0]        prod;
  logic [31:0]        acc;
  logic [15:0]        row_ctr;

  logic        out_free;
  logic        take_mul;
  logic        take_close;
  logic        norm_more;
  logic [31:0] rnd_bits;

  // multiply operands
  logic [7:0]         ea, eb, eae, ebe;
  logic [23:0]        ma, mb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic               m_sgn;
  logic               m_spec;
  logic [31:0]        m_bits;
  logic [47:0]        m_prod;
  logic signed [10:0] m_x;

  // add operands
  logic               a_swap;
  logic [31:0]        lop, sop;
  logic [7:0]         le, se, lee, see, a_d;
  logic [23:0]        lm, sm;
  logic               l_nan, s_nan, l_inf, s_inf;
  logic [47:0]        a_big, a_al, a_sum;
  logic signed [10:0] a_x;
  logic               a_spec;
  logic [31:0]        a_bits;

  assign out_free = !result_valid || !result_stall;
  assign norm_more = !spec && (mant[47:40] == 8'd0);
  assign rnd_bits = spec ? spec_bits : norm_round(sgn, xexp, mant);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (head.valid && !head.op.close) state_next = B_MNORM;
      end
      B_MNORM: begin
        if (!norm_more) state_next = B_ADD;
      end
      B_ADD: begin
        state_next = B_ANORM;
      end
      B_ANORM: begin
        if (!norm_more) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    take_mul = 1'b0;
    take_close = 1'b0;
    case (state)
      B_IDLE: begin
        take_mul = head.valid && !head.op.close;
        take_close = head.valid && head.op.close && out_free;
      end
      default: ;
    endcase
  end

  assign pop = take_mul || take_close;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // multiply: unpack, specials, 24x24 mantissa product
  always_comb begin
    ea = head.op.mval[30:23];
    eb = head.op.xval[30:23];
    ma = {(ea != 8'd0), head.op.mval[22:0]};
    mb = {(eb != 8'd0), head.op.xval[22:0]};
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    a_nan = (ea == 8'hFF) && (head.op.mval[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (head.op.xval[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (head.op.mval[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (head.op.xval[22:0] == 23'd0);
    a_zero = (head.op.mval[30:0] == 31'd0);
    b_zero = (head.op.xval[30:0] == 31'd0);
    m_sgn = head.op.mval[31] ^ head.op.xval[31];
    m_spec = 1'b1;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) m_bits = CANON_NAN;
    else if (a_inf || b_inf) m_bits = {m_sgn, 8'hFF, 23'd0};
    else if (a_zero || b_zero) m_bits = {m_sgn, 31'd0};
    else begin
      m_bits = 32'd0;
      m_spec = 1'b0;
    end
    m_prod = ma * mb;
    m_x = signed'({3'b0, eae}) + signed'({3'b0, ebe}) - 11'sd126;
  end

  // add: order by magnitude, align the smaller one, add or subtract
  always_comb begin
    a_swap = prod[30:0] > acc[30:0];
    lop = a_swap ? prod : acc;
    sop = a_swap ? acc : prod;
    le = lop[30:23];
    se = sop[30:23];
    lm = {(le != 8'd0), lop[22:0]};
    sm = {(se != 8'd0), sop[22:0]};
    lee = (le == 8'd0) ? 8'd1 : le;
    see = (se == 8'd0) ? 8'd1 : se;
    a_d = lee - see;
    l_nan = (le == 8'hFF) && (lop[22:0] != 23'd0);
    s_nan = (se == 8'hFF) && (sop[22:0] != 23'd0);
    l_inf = (le == 8'hFF) && (lop[22:0] == 23'd0);
    s_inf = (se == 8'hFF) && (sop[22:0] == 23'd0);
    a_big = {1'b0, lm, 23'd0};
    a_al = shr_sticky({1'b0, sm, 23'd0}, {3'b0, a_d});
    a_sum = (lop[31] ^ sop[31]) ? (a_big - a_al) : (a_big + a_al);
    a_x = signed'({3'b0, lee}) + 11'sd1;
    a_spec = 1'b1;
    if (l_nan || s_nan || (l_inf && s_inf && (lop[31] != sop[31]))) a_bits = CANON_NAN;
    else if (l_inf) a_bits = lop;
    else if (a_sum == 48'd0) a_bits = {lop[31] & sop[31], 31'd0};  // exact cancel is +0
    else begin
      a_bits = 32'd0;
      a_spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (take_mul) begin
          mant <= m_prod;
          xexp <= m_x;
          sgn <= m_sgn;
          spec <= m_spec;
          spec_bits <= m_bits;
        end
      end
      B_MNORM: begin
        if (norm_more) begin
          mant <= mant << 8;
          xexp <= xexp - 11'sd8;
        end else begin
          prod <= rnd_bits;
        end
      end
      B_ADD: begin
        mant <= a_sum;
        xexp <= a_x;
        sgn <= lop[31];
        spec <= a_spec;
        spec_bits <= a_bits;
      end
      B_ANORM: begin
        if (norm_more) begin
          mant <= mant << 8;
          xexp <= xexp - 11'sd8;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
      row_ctr <= 16'd0;
    end else if (take_close) begin
      acc <= 32'd0;
      row_ctr <= row_ctr + 16'd1;
    end else if ((state == B_ANORM) && !norm_more) begin
      acc <= rnd_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (take_close) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take_close) begin
      result.row_sum <= acc;
      result.row_number <= row_ctr;
    end
  end

endmodule

### sv/csr_sparse_matrix_vector_multiply_core.sv
// CSR SpMV core: front end, operation queue, float multiply-accumulate back end.
// Loads write the vector store directly; a nonzero holds the back end in its multiply,
// normalize, add and normalize states, repeating a normalize step per zero top byte.
// A close beat goes through the pending register and queue into the result register.
// The serial multiply/round/add/round chain on the running sum sets the nonzero rate.
// Reset: queue emptied, running sum +0.0, row counter 0; the vector store is not cleared.
module csr_sparse_matrix_vector_multiply_core import csrspmv_pkg::*; #(
  parameter int VEC_DEPTH = VecDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  in_t  item,
  output logic result_valid,
  input  logic result_stall,
  output out_t result
);

  q_beat_t          push;
  q_beat_t          head;
  logic             pop;
  logic [QCntW-1:0] q_count;

  csrspmv_front #(
    .VEC_DEPTH(VEC_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .item_stall(item_stall),
    .q_count   (q_count),
    .push      (push)
  );

  csrspmv_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .count(q_count)
  );

  csrspmv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

### sv/csrspmv_checker.sv
// Port-level checks for the CSR SpMV core, bound to the top level
`include "assert_macros.svh"

module csrspmv_checker import csrspmv_pkg::*; (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_stall,
  input out_t result
);

  logic        seen;
  logic [15:0] last_row;
  logic        beat;

  assign beat = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) seen <= 1'b0;
    else if (beat) seen <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (beat) last_row <= result.row_number;
  end

  `CSRSPMV_ASSERT_NEXT(a_hold_valid, clk, rst, result_valid && result_stall, result_valid)
  `CSRSPMV_ASSERT_NEXT(a_hold_data, clk, rst, result_valid && result_stall, $stable(result))
  `CSRSPMV_ASSERT_NOW(a_reset_quiet, clk, $past(rst), !result_valid)
  `CSRSPMV_ASSERT_IMPL(a_row_seq, clk, rst, beat && seen, result.row_number == last_row + 16'd1)

endmodule

bind csr_sparse_matrix_vector_multiply_core csrspmv_checker u_chk (.*);

### verif/tb_csr_sparse_matrix_vector_multiply_core.sv
// Testbench for the CSR SpMV core: directed and random beats checked against a float dot-product predictor
module tb_csr_sparse_matrix_vector_multiply_core;
  import csrspmv_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RandItems = 1800;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  in_t  item;
  logic result_valid;
  logic result_stall;
  out_t result;

  csr_sparse_matrix_vector_multiply_core u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  in_t  beat_q[$];
  out_t row_result_q[$];
  bit   failed;
  bit   in_took;

  // predictor state
  logic [31:0] vec_mirror[VecDepthDefault];
  logic [31:0] acc_sum;
  logic [15:0] row_cnt;

  // round an exact value m * 2^ex to single, nearest even, subnormals kept
  function automatic logic [31:0] pack_single(input bit s, input logic [127:0] m, input int ex);
    int msb;
    int top;
    int lsb;
    int sh;
    logic [127:0] kept;
    logic [127:0] rem;
    logic [127:0] half;
    logic [127:0] mask;
    int fld;
    msb = -1;
    if (m == '0) return {s, 31'b0};
    for (int i = 0; i < 128; i++) if (m[i]) msb = i;
    top = msb + ex;
    if (top > 127) return {s, 8'hFF, 23'b0};
    lsb = (top >= -126) ? top - 23 : -149;
    sh = lsb - ex;
    if (sh <= 0) begin
      kept = m << (-sh);
    end else if (sh > 128) begin
      kept = '0;
    end else begin
      kept = m >> sh;
      mask = (sh == 128) ? '1 : ((128'd1 << sh) - 128'd1);
      rem = m & mask;
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 128'd1;
    end
    if (kept == (128'd1 << 24)) begin
      kept = 128'd1 << 23;
      lsb = lsb + 1;
    end
    if (kept >= (128'd1 << 23)) begin
      fld = lsb + 150;
      if (fld > 254) return {s, 8'hFF, 23'b0};
      return {s, fld[7:0], kept[22:0]};
    end
    return {s, 8'd0, kept[22:0]};
  endfunction

  function automatic bit is_nan(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != '0;
  endfunction

  function automatic bit is_inf(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] == '0;
  endfunction

  function automatic void split_single(input logic [31:0] b, output logic [127:0] m,
                                       output int ex);
    if (b[30:23] == 8'd0) begin
      m = {105'd0, b[22:0]};
      ex = -149;
    end else begin
      m = {104'd0, 1'b1, b[22:0]};
      ex = int'(b[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    int ea;
    int eb;
    bit s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == '0 || b[30:0] == '0) return CANON_NAN;
      return {s, 8'hFF, 23'b0};
    end
    split_single(a, ma, ea);
    split_single(b, mb, eb);
    return pack_single(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] hi;
    logic [127:0] lo;
    int ea;
    int eb;
    int d;
    int dd;
    bit s;
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CANON_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    split_single(a, ma, ea);
    split_single(b, mb, eb);
    // put the larger exponent in a
    if (eb > ea) begin
      {ma, mb} = {mb, ma};
      {ea, eb} = {eb, ea};
      s = b[31];
      b = a;
      a = {s, a[30:0]};
    end
    d = ea - eb;
    dd = (d > 62) ? 62 : d;
    ma = ma << dd;
    // far-below operand collapses to a sticky unit under the round bit
    if (d > 62) mb = (mb != '0) ? 128'd1 : '0;
    if (a[31] == b[31]) begin
      return pack_single(a[31], ma + mb, ea - dd);
    end
    if (ma == mb) return {a[31] & b[31], 31'b0};
    if (ma > mb) begin
      hi = ma; lo = mb; s = a[31];
    end else begin
      hi = mb; lo = ma; s = b[31];
    end
    return pack_single(s, hi - lo, ea - dd);
  endfunction

  task automatic predict_beat(input in_t b);
    out_t r;
    logic [31:0] sum;
    case (b.mode)
      MODE_LOAD: vec_mirror[b.index] = b.value;
      MODE_NONZERO: begin
        sum = fadd(acc_sum, fmul(b.value, vec_mirror[b.index]));
        acc_sum = is_nan(sum) ? CANON_NAN : sum;
      end
      MODE_CLOSE: begin
        r.row_sum = acc_sum;
        r.row_number = row_cnt;
        row_result_q.push_back(r);
        acc_sum = '0;
        row_cnt = row_cnt + 16'd1;
      end
      default: ;
    endcase
  endtask

  // sender: bursts and gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) in_took <= item_valid && !item_stall && !rst;

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (in_took) predict_beat(item);
      if (!item_valid || in_took) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          item_valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          item <= beat_q.pop_front();
          item_valid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int rx_cycles;
  int hold_left;
  int stall_pct;

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      rx_cycles = rx_cycles + 1;
      if (rx_cycles == 300) hold_left = 400;
      if (rx_cycles % 500 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (row_result_q.size() == 0) begin
        $display("%0t: unexpected result beat sum=%h row=%0d", $time, result.row_sum,
                 result.row_number);
        failed = 1'b1;
      end else begin
        if (result.row_sum !== row_result_q[0].row_sum) begin
          $display("%0t: row_sum expected %h actual %h", $time, row_result_q[0].row_sum,
                   result.row_sum);
          failed = 1'b1;
        end
        if (result.row_number !== row_result_q[0].row_number) begin
          $display("%0t: row_number expected %0d actual %0d", $time,
                   row_result_q[0].row_number, result.row_number);
          failed = 1'b1;
        end
        void'(row_result_q.pop_front());
      end
    end
  end

  // stimulus generation
  int written_idx[$];
  bit is_written[VecDepthDefault];

  function automatic logic [31:0] rand_single();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: f[30:23] = 8'($urandom_range(100, 154));
      5: f[30:23] = 8'd0;
      6: f[30:0] = '0;
      7: f[30:0] = {8'hFF, 23'b0};
      8: begin
        f[30:23] = 8'hFF;
        if (f[22:0] == '0) f[0] = 1'b1;
      end
      default: ;
    endcase
    return f;
  endfunction

  task automatic push_beat(input logic [1:0] mode, input int idx, input logic [31:0] val);
    in_t b;
    b.mode = mode;
    b.index = 10'(idx);
    b.value = val;
    if (mode == MODE_LOAD && !is_written[idx]) begin
      is_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
    beat_q.push_back(b);
  endtask

  initial begin
    int n;
    int k;
    failed = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    burst_left = 1;
    gap_left = 0;
    rx_cycles = 0;
    hold_left = 0;
    stall_pct = 30;
    acc_sum = '0;
    row_cnt = '0;

    // directed: extremes, specials, unused mode
    push_beat(MODE_LOAD, 0, 32'h3F80_0000);
    push_beat(MODE_LOAD, 1023, 32'hFFFF_FFFF);
    push_beat(MODE_LOAD, 512, 32'h7F7F_FFFF);
    push_beat(MODE_LOAD, 1, 32'h0000_0001);
    push_beat(MODE_LOAD, 2, 32'h7F80_0000);
    push_beat(MODE_LOAD, 3, 32'h0000_0000);
    push_beat(MODE_CLOSE, 0, 32'h0);                // empty row
    push_beat(MODE_NONZERO, 0, 32'h3F80_0000);
    push_beat(MODE_NONZERO, 3, 32'h8000_0000);
    push_beat(MODE_CLOSE, 1023, 32'hFFFF_FFFF);
    push_beat(MODE_NONZERO, 512, 32'h7F7F_FFFF);   // overflow to inf
    push_beat(MODE_CLOSE, 0, 32'h0);
    push_beat(MODE_NONZERO, 2, 32'h0000_0000);     // inf * 0
    push_beat(MODE_NONZERO, 0, 32'h3F80_0000);
    push_beat(MODE_CLOSE, 0, 32'h0);
    push_beat(MODE_NONZERO, 1, 32'h3F00_0000);     // subnormal rounding
    push_beat(MODE_UNUSED, 1023, 32'hFFFF_FFFF);
    push_beat(MODE_CLOSE, 0, 32'h0);
    push_beat(MODE_NONZERO, 1023, 32'h3F80_0000);  // NaN operand
    push_beat(MODE_CLOSE, 0, 32'h0);
    push_beat(MODE_NONZERO, 0, 32'h3F80_0000);     // exact cancellation
    push_beat(MODE_NONZERO, 0, 32'hBF80_0000);
    push_beat(MODE_CLOSE, 0, 32'h0);

    // random: mostly well-formed rows over written entries
    n = 0;
    while (n < RandItems) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          push_beat(MODE_LOAD, $urandom_range(0, VecDepthDefault - 1), rand_single());
          n++;
        end
        3: begin
          push_beat(MODE_UNUSED, $urandom_range(0, 1023), $urandom);
        end
        default: begin
          k = $urandom_range(0, 8);
          repeat (k) begin
            push_beat(MODE_NONZERO, written_idx[$urandom_range(0, written_idx.size() - 1)],
                      rand_single());
            n++;
          end
          push_beat(MODE_CLOSE, $urandom_range(0, 1023), $urandom);
          n++;
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (beat_q.size() != 0 || item_valid || row_result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
